// ===== design/rpvf_pkg.sv =====
package rpvf_pkg;

	// Default sizes of the profile store and of the offset clamp
	localparam int DEF_TABLE_DEPTH = 32768;
	localparam int DEF_GRID_HALF   = 1024;

	// Pipeline shape
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 16;
	localparam int LANES      = 6;
	localparam int PIPE_LAT   = 60;

	// Register map
	typedef enum logic [2:0] {
		REG_GRID_STEP    = 3'd0,
		REG_TAB_SPACING  = 3'd1,
		REG_TAB_INV      = 3'd2,
		REG_TAB_ENTRIES  = 3'd3,
		REG_FAR_PHI1     = 3'd4,
		REG_FAR_PHI2     = 3'd5,
		REG_FAR_GAUGE    = 3'd6,
		REG_CORE_CUTOFF  = 3'd7
	} rpvf_reg_t;

	localparam logic [15:0] RST_GRID_STEP   = 16'd2867;
	localparam logic [15:0] RST_TAB_SPACING = 16'd655;
	localparam logic [15:0] RST_TAB_INV     = 16'd25600;
	localparam logic [15:0] RST_TAB_ENTRIES = 16'd20001;
	localparam logic [15:0] RST_FAR_PHI1    = 16'd8192;
	localparam logic [15:0] RST_FAR_PHI2    = 16'd8192;
	localparam logic [15:0] RST_FAR_GAUGE   = 16'd18318;
	localparam logic [15:0] RST_CORE_CUTOFF = 16'd4588;

	// Per-item data that rides along the front of the pipe
	typedef struct packed {
		logic               act;
		logic [14:0]        idx;
		logic signed [15:0] e1;
		logic signed [15:0] e2;
		logic signed [15:0] eg;
		logic signed [26:0] x;
		logic signed [26:0] y;
		logic [52:0]        sum;
	} rpvf_carry_t;

	// Square root partial state
	typedef struct packed {
		logic [33:0] rem;
		logic [30:0] root;
	} rpvf_sqrt_t;

	// Divider lane state
	typedef struct packed {
		logic [56:0] rem;
		logic [52:0] den;
		logic        neg;
		logic        sat;
		logic [15:0] quo;
	} rpvf_div_t;

	// Point status that travels with the divider lanes
	typedef struct packed {
		logic zero;
		logic off;
	} rpvf_tag_t;

	// One digit of the integer square root
	function automatic rpvf_sqrt_t sqrt_step(rpvf_sqrt_t v, logic [1:0] pair);
		logic [33:0] cur;
		logic [33:0] trial;
		rpvf_sqrt_t  r;
		cur   = {v.rem[31:0], pair};
		trial = {1'b0, v.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {v.root[29:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {v.root[29:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit of the long division
	function automatic rpvf_div_t div_step(rpvf_div_t v, int b);
		logic [68:0] sh;
		logic [68:0] rx;
		rpvf_div_t   r;
		sh = 69'(v.den) << b;
		rx = 69'(v.rem);
		r  = v;
		if (!v.sat && rx >= sh) begin
			r.rem    = v.rem - sh[56:0];
			r.quo[b] = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== design/radial_profile_vortex_field_top.sv =====
// Radial profile vortex field evaluator, Q3.13 fixed point.
// Command channel: an item is taken at each clock edge with start high and
// busy low; busy never rises, so one item may enter in every cycle. A load
// item (action 0) writes one entry of the three profile tables and gives no
// result. A point item (action 1) gives exactly one result: done is high for
// one cycle with the six field components and off_table on their ports.
// The result passes the 31-step square root and the 16-step dividers; the
// rate is one item per cycle, as every step has its own pipeline stage and
// the three table reads use three copies of the store.
// Results leave in input order. The receiver cannot hold them off and the
// pipeline never stalls. Loads act on the store in order with the points,
// so a point sees exactly the loads that came before it.
// Configuration: cfg_write, cfg_index, cfg_data write one register per
// edge; write only while no point is in flight.
// Reset clears the valid bits and loads the register defaults; table
// entries hold nothing until loaded.
module radial_profile_vortex_field_top import rpvf_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int GRID_HALF   = DEF_GRID_HALF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [14:0]        entry_index,
	input  logic signed [15:0] entry_phi1,
	input  logic signed [15:0] entry_phi2,
	input  logic signed [15:0] entry_gauge,
	input  logic signed [10:0] offset_x,
	input  logic signed [10:0] offset_y,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic signed [15:0] phi1_x,
	output logic signed [15:0] phi1_y,
	output logic signed [15:0] phi2_x,
	output logic signed [15:0] phi2_y,
	output logic signed [15:0] gauge_x,
	output logic signed [15:0] gauge_y,
	output logic               off_table
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic signed [13:0] OFF_LO = 14'(-GRID_HALF);
	localparam logic signed [13:0] OFF_HI = 14'(GRID_HALF - 1);
	localparam logic [16:0] DEPTH17 = 17'(TABLE_DEPTH);

	// Configuration registers
	logic [15:0] grid_step_q, tab_spacing_q, tab_inv_q, tab_entries_q;
	logic [15:0] far_phi1_q, far_phi2_q, far_gauge_q, core_cutoff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_step_q   <= RST_GRID_STEP;
			tab_spacing_q <= RST_TAB_SPACING;
			tab_inv_q     <= RST_TAB_INV;
			tab_entries_q <= RST_TAB_ENTRIES;
			far_phi1_q    <= RST_FAR_PHI1;
			far_phi2_q    <= RST_FAR_PHI2;
			far_gauge_q   <= RST_FAR_GAUGE;
			core_cutoff_q <= RST_CORE_CUTOFF;
		end else if (cfg_write) begin
			case (rpvf_reg_t'(cfg_index))
				REG_GRID_STEP:   grid_step_q   <= cfg_data;
				REG_TAB_SPACING: tab_spacing_q <= cfg_data;
				REG_TAB_INV:     tab_inv_q     <= cfg_data;
				REG_TAB_ENTRIES: tab_entries_q <= cfg_data;
				REG_FAR_PHI1:    far_phi1_q    <= cfg_data;
				REG_FAR_PHI2:    far_phi2_q    <= cfg_data;
				REG_FAR_GAUGE:   far_gauge_q   <= cfg_data;
				REG_CORE_CUTOFF: core_cutoff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The table step is carried by its reciprocal; keep it as a plain register
	logic spacing_set;
	assign spacing_set = |tab_spacing_q;

	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Stage 1: take the transaction, clamp the offsets
	logic signed [13:0] oxw, oyw;
	logic signed [10:0] oxc, oyc;

	always_comb begin
		oxw = 14'(offset_x);
		oyw = 14'(offset_y);
		if (oxw < OFF_LO)
			oxw = OFF_LO;
		else if (oxw > OFF_HI)
			oxw = OFF_HI;
		if (oyw < OFF_LO)
			oyw = OFF_LO;
		else if (oyw > OFF_HI)
			oyw = OFF_HI;
		oxc = oxw[10:0];
		oyc = oyw[10:0];
	end

	logic               vld_s1, act_s1;
	logic [14:0]        idx_s1;
	logic signed [15:0] e1_s1, e2_s1, eg_s1;
	logic signed [10:0] ox_s1, oy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		act_s1 <= action;
		idx_s1 <= entry_index;
		e1_s1  <= entry_phi1;
		e2_s1  <= entry_phi2;
		eg_s1  <= entry_gauge;
		ox_s1  <= oxc;
		oy_s1  <= oyc;
	end

	// ---------------------------------------------------------------
	// Stage 2: scale offsets by the lattice step
	logic signed [27:0] xp, yp;
	assign xp = ox_s1 * $signed({1'b0, grid_step_q});
	assign yp = oy_s1 * $signed({1'b0, grid_step_q});

	logic               vld_s2, act_s2;
	logic [14:0]        idx_s2;
	logic signed [15:0] e1_s2, e2_s2, eg_s2;
	logic signed [26:0] x_s2, y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		act_s2 <= act_s1;
		idx_s2 <= idx_s1;
		e1_s2  <= e1_s1;
		e2_s2  <= e2_s1;
		eg_s2  <= eg_s1;
		x_s2   <= xp[26:0];
		y_s2   <= yp[26:0];
	end

	// ---------------------------------------------------------------
	// Stage 3: square both coordinates
	logic signed [53:0] xsq, ysq;
	assign xsq = x_s2 * x_s2;
	assign ysq = y_s2 * y_s2;

	logic               vld_s3, act_s3;
	logic [14:0]        idx_s3;
	logic signed [15:0] e1_s3, e2_s3, eg_s3;
	logic signed [26:0] x_s3, y_s3;
	logic [51:0]        xx_s3, yy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		act_s3 <= act_s2;
		idx_s3 <= idx_s2;
		e1_s3  <= e1_s2;
		e2_s3  <= e2_s2;
		eg_s3  <= eg_s2;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		xx_s3  <= xsq[51:0];
		yy_s3  <= ysq[51:0];
	end

	// ---------------------------------------------------------------
	// Stage 4 and square root: sum of squares, then one root digit a stage
	logic        sqv_s [SQRT_STEPS+1];
	rpvf_carry_t sqc_s [SQRT_STEPS+1];
	rpvf_sqrt_t  sqr_s [SQRT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sqv_s[0] <= 1'b0;
		else
			sqv_s[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		sqc_s[0].act <= act_s3;
		sqc_s[0].idx <= idx_s3;
		sqc_s[0].e1  <= e1_s3;
		sqc_s[0].e2  <= e2_s3;
		sqc_s[0].eg  <= eg_s3;
		sqc_s[0].x   <= x_s3;
		sqc_s[0].y   <= y_s3;
		sqc_s[0].sum <= 53'(xx_s3) + 53'(yy_s3);
		sqr_s[0]     <= '0;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [61:0] radicand;
		assign radicand = {1'b0, sqc_s[k].sum, 8'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[k+1] <= 1'b0;
			else
				sqv_s[k+1] <= sqv_s[k];
		end

		always_ff @(posedge clk) begin
			sqc_s[k+1] <= sqc_s[k];
			sqr_s[k+1] <= sqrt_step(sqr_s[k], radicand[61-2*k -: 2]);
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: distance in table steps, core test
	logic [30:0] root_d;
	assign root_d = sqr_s[SQRT_STEPS].root;

	logic        vld_s5, zero_s5;
	rpvf_carry_t cr_s5;
	logic [30:0] d_s5;
	logic [46:0] u_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= sqv_s[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		cr_s5   <= sqc_s[SQRT_STEPS];
		d_s5    <= root_d;
		u_s5    <= 47'(root_d) * 47'(tab_inv_q);
		zero_s5 <= (root_d == '0) || (root_d < 31'(core_cutoff_q)) || !spacing_set && 1'b0;
	end

	// ---------------------------------------------------------------
	// Stage 6: nearest entry, fraction, off-table test, read addresses
	logic [47:0]        ur;
	logic [23:0]        pidx;
	logic signed [24:0] frac;
	logic [16:0]        nent;
	logic               off_c, p0_c, ldok_c;
	logic [AW-1:0]      pa;

	always_comb begin
		ur     = {1'b0, u_s5} + 48'h800000;
		pidx   = ur[47:24];
		frac   = $signed({1'b0, ur[23:0]}) - 25'sh0800000;
		nent   = (17'(tab_entries_q) < DEPTH17) ? 17'(tab_entries_q) : DEPTH17;
		off_c  = (25'(pidx) + 25'd1) >= 25'(nent);
		p0_c   = (pidx == '0);
		pa     = pidx[AW-1:0];
		ldok_c = 17'(cr_s5.idx) < DEPTH17;
	end

	logic               vld_s6, zero_s6, off_s6, p0_s6, ldok_s6;
	rpvf_carry_t        cr_s6;
	logic [30:0]        d_s6;
	logic signed [24:0] s_s6;
	logic [AW-1:0]      am_s6, a0_s6, ap_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		cr_s6   <= cr_s5;
		d_s6    <= d_s5;
		zero_s6 <= zero_s5;
		off_s6  <= off_c;
		p0_s6   <= p0_c;
		ldok_s6 <= ldok_c;
		s_s6    <= frac;
		am_s6   <= p0_c ? '0 : pa - 1'b1;
		a0_s6   <= pa;
		ap_s6   <= pa + 1'b1;
	end

	// ---------------------------------------------------------------
	// Stage 7: profile store (three copies, one per read), weights
	logic [47:0] mem_m [TABLE_DEPTH];
	logic [47:0] mem_0 [TABLE_DEPTH];
	logic [47:0] mem_p [TABLE_DEPTH];
	logic [47:0] rd_m_s7, rd_0_s7, rd_p_s7;
	logic [AW-1:0] ld_addr;

	assign ld_addr = AW'(cr_s6.idx);

	always_ff @(posedge clk) begin
		if (vld_s6 && !cr_s6.act && ldok_s6) begin
			mem_m[ld_addr] <= {cr_s6.e1, cr_s6.e2, cr_s6.eg};
			mem_0[ld_addr] <= {cr_s6.e1, cr_s6.e2, cr_s6.eg};
			mem_p[ld_addr] <= {cr_s6.e1, cr_s6.e2, cr_s6.eg};
		end
		rd_m_s7 <= mem_m[am_s6];
		rd_0_s7 <= mem_0[a0_s6];
		rd_p_s7 <= mem_p[ap_s6];
	end

	// Lagrange weights, or linear ones at the first entry
	logic signed [25:0] sm, sp;
	logic signed [50:0] pm, ps, pq;
	logic signed [50:0] tm, ts, tq;
	logic signed [26:0] wm_c, w0_c, wp_c;

	always_comb begin
		sm = 26'(s_s6) - 26'sh1000000;
		sp = 26'(s_s6) + 26'sh1000000;
		pm = s_s6 * sm;
		ps = s_s6 * s_s6;
		pq = s_s6 * sp;
		tm = pm + 51'sh1000000;
		ts = ps + 51'sh0800000;
		tq = pq + 51'sh1000000;
		if (p0_s6) begin
			wm_c = '0;
			w0_c = 27'sh1000000 - 27'(s_s6);
			wp_c = 27'(s_s6);
		end else begin
			wm_c = 27'(tm >>> 25);
			w0_c = 27'sh1000000 - 27'(ts >>> 24);
			wp_c = 27'(tq >>> 25);
		end
	end

	logic               vld_s7, zero_s7, off_s7;
	logic signed [26:0] x_s7, y_s7;
	logic [52:0]        sum_s7;
	logic [30:0]        d_s7;
	logic signed [26:0] w_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else
			vld_s7 <= vld_s6 && cr_s6.act;
	end

	always_ff @(posedge clk) begin
		x_s7    <= cr_s6.x;
		y_s7    <= cr_s6.y;
		sum_s7  <= cr_s6.sum;
		d_s7    <= d_s6;
		zero_s7 <= zero_s6;
		off_s7  <= off_s6;
		w_s7[0] <= wm_c;
		w_s7[1] <= w0_c;
		w_s7[2] <= wp_c;
	end

	// ---------------------------------------------------------------
	// Stage 8: weight times entry, three profiles by three taps
	logic signed [15:0] tv [3][3];

	always_comb begin
		tv[0][0] = rd_m_s7[47:32];
		tv[1][0] = rd_m_s7[31:16];
		tv[2][0] = rd_m_s7[15:0];
		tv[0][1] = rd_0_s7[47:32];
		tv[1][1] = rd_0_s7[31:16];
		tv[2][1] = rd_0_s7[15:0];
		tv[0][2] = rd_p_s7[47:32];
		tv[1][2] = rd_p_s7[31:16];
		tv[2][2] = rd_p_s7[15:0];
	end

	logic signed [42:0] pr_c [3][3];

	always_comb begin
		for (int j = 0; j < 3; j++)
			for (int t = 0; t < 3; t++)
				pr_c[j][t] = w_s7[t] * tv[j][t];
	end

	logic               vld_s8, zero_s8, off_s8;
	logic signed [26:0] x_s8, y_s8;
	logic [52:0]        sum_s8;
	logic [30:0]        d_s8;
	logic signed [42:0] pr_s8 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s8 <= 1'b0;
		else
			vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		x_s8    <= x_s7;
		y_s8    <= y_s7;
		sum_s8  <= sum_s7;
		d_s8    <= d_s7;
		zero_s8 <= zero_s7;
		off_s8  <= off_s7;
		pr_s8   <= pr_c;
	end

	// ---------------------------------------------------------------
	// Stage 9: sum the taps, round to Q3.13, or take the far values
	logic signed [44:0] acc [3];
	logic signed [44:0] accr [3];
	logic signed [17:0] mag_c [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j]  = 45'(pr_s8[j][0]) + 45'(pr_s8[j][1]) + 45'(pr_s8[j][2]);
			accr[j] = acc[j] + 45'sh0800000;
			mag_c[j] = 18'(accr[j] >>> 24);
		end
		if (off_s8) begin
			mag_c[0] = 18'($signed(far_phi1_q));
			mag_c[1] = 18'($signed(far_phi2_q));
			mag_c[2] = 18'($signed(far_gauge_q));
		end
	end

	logic               vld_s9, zero_s9, off_s9;
	logic signed [26:0] x_s9, y_s9;
	logic [52:0]        sum_s9;
	logic [30:0]        d_s9;
	logic signed [17:0] m_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s9 <= 1'b0;
		else
			vld_s9 <= vld_s8;
	end

	always_ff @(posedge clk) begin
		x_s9    <= x_s8;
		y_s9    <= y_s8;
		sum_s9  <= sum_s8;
		d_s9    <= d_s8;
		zero_s9 <= zero_s8;
		off_s9  <= off_s8;
		m_s9    <= mag_c;
	end

	// ---------------------------------------------------------------
	// Stage 10: magnitude times coordinate for each component
	logic signed [18:0] mop [LANES];
	logic signed [26:0] cop [LANES];
	logic signed [45:0] np_c [LANES];

	always_comb begin
		mop[0] = 19'(m_s9[0]);
		cop[0] = x_s9;
		mop[1] = 19'(m_s9[0]);
		cop[1] = y_s9;
		mop[2] = 19'(m_s9[1]);
		cop[2] = x_s9;
		mop[3] = 19'(m_s9[1]);
		cop[3] = y_s9;
		mop[4] = -19'(m_s9[2]);
		cop[4] = y_s9;
		mop[5] = 19'(m_s9[2]);
		cop[5] = x_s9;
		for (int l = 0; l < LANES; l++)
			np_c[l] = mop[l] * cop[l];
	end

	logic               vld_s10, zero_s10, off_s10;
	logic [52:0]        sum_s10;
	logic [30:0]        d_s10;
	logic signed [45:0] np_s10 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s10 <= 1'b0;
		else
			vld_s10 <= vld_s9;
	end

	always_ff @(posedge clk) begin
		sum_s10  <= sum_s9;
		d_s10    <= d_s9;
		zero_s10 <= zero_s9;
		off_s10  <= off_s9;
		np_s10   <= np_c;
	end

	// ---------------------------------------------------------------
	// Stage 11: scale, take the magnitude, add half the divisor
	logic signed [57:0] nv [LANES];
	logic [56:0]        nmag [LANES];
	logic [52:0]        den_c [LANES];
	rpvf_div_t          g_c [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (l < 4) begin
				nv[l]    = 58'(np_s10[l]) <<< 4;
				den_c[l] = 53'(d_s10);
			end else begin
				nv[l]    = 58'(np_s10[l]) <<< 12;
				den_c[l] = sum_s10;
			end
			nmag[l]     = nv[l][57] ? 57'(-nv[l]) : nv[l][56:0];
			g_c[l].rem  = nmag[l] + 57'(den_c[l] >> 1);
			g_c[l].den  = den_c[l];
			g_c[l].neg  = nv[l][57];
			g_c[l].sat  = 1'b0;
			g_c[l].quo  = '0;
		end
	end

	logic      vld_s11;
	rpvf_tag_t tag_s11;
	rpvf_div_t g_s11 [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s11 <= 1'b0;
		else
			vld_s11 <= vld_s10;
	end

	always_ff @(posedge clk) begin
		tag_s11.zero <= zero_s10;
		tag_s11.off  <= off_s10;
		g_s11        <= g_c;
	end

	// ---------------------------------------------------------------
	// Overflow precheck, then one quotient bit a stage
	logic      dvv_s [DIV_STEPS+1];
	rpvf_tag_t dvt_s [DIV_STEPS+1];
	rpvf_div_t dvl_s [DIV_STEPS+1][LANES];
	rpvf_div_t pre_c [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pre_c[l]     = g_s11[l];
			pre_c[l].sat = 69'(g_s11[l].rem) >= {g_s11[l].den, 16'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvv_s[0] <= 1'b0;
		else
			dvv_s[0] <= vld_s11;
	end

	always_ff @(posedge clk) begin
		dvt_s[0] <= tag_s11;
		dvl_s[0] <= pre_c;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvv_s[k+1] <= 1'b0;
			else
				dvv_s[k+1] <= dvv_s[k];
		end

		always_ff @(posedge clk) begin
			dvt_s[k+1] <= dvt_s[k];
			for (int l = 0; l < LANES; l++)
				dvl_s[k+1][l] <= div_step(dvl_s[k][l], DIV_STEPS - 1 - k);
		end
	end

	// ---------------------------------------------------------------
	// Output: sign, saturate, zero inside the core
	logic signed [15:0] res_c [LANES];
	rpvf_div_t          fin [LANES];
	rpvf_tag_t          fin_tag;

	always_comb begin
		fin_tag = dvt_s[DIV_STEPS];
		for (int l = 0; l < LANES; l++) begin
			fin[l] = dvl_s[DIV_STEPS][l];
			if (fin_tag.zero)
				res_c[l] = '0;
			else if (!fin[l].neg)
				res_c[l] = (fin[l].sat || fin[l].quo > 16'd32767) ?
					16'sh7FFF : $signed(fin[l].quo);
			else
				res_c[l] = (fin[l].sat || fin[l].quo > 16'd32768) ?
					16'sh8000 : $signed(-fin[l].quo);
		end
	end

	logic               done_q, off_q;
	logic signed [15:0] res_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			off_q  <= 1'b0;
		end else begin
			done_q <= dvv_s[DIV_STEPS];
			off_q  <= dvv_s[DIV_STEPS] && fin_tag.off && !fin_tag.zero;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done      = done_q;
	assign off_table = off_q;
	assign phi1_x    = res_q[0];
	assign phi1_y    = res_q[1];
	assign phi2_x    = res_q[2];
	assign phi2_y    = res_q[3];
	assign gauge_x   = res_q[4];
	assign gauge_y   = res_q[5];

endmodule

// ===== design/rpvf_check.sv =====
module rpvf_check import rpvf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic action,
	input logic done,
	input logic off_table
);

	// Count edges since reset until the pipeline has drained once
	logic [6:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			warm_q <= '0;
		else if (warm_q != 7'(PIPE_LAT))
			warm_q <= warm_q + 7'd1;
	end

	// Each point transaction gives exactly one result, a fixed time later
	a_done_follows_point: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 7'(PIPE_LAT)) |-> (done == $past(start && !busy && action, PIPE_LAT)))
		else $error("result strobe does not match point transactions");

	// The block takes one transaction in every cycle
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// The off-table flag only marks a delivered result
	a_off_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		off_table |-> done)
		else $error("off_table without result");

endmodule

bind radial_profile_vortex_field_top rpvf_check u_rpvf_check (.*);

// ===== test/radial_profile_vortex_field_top_tb.sv =====
module radial_profile_vortex_field_top_tb;
	import rpvf_pkg::*;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_POINT = 1'b1;
	localparam int   NUM_PHASES = 6;
	localparam int   CYCLE_LIMIT = 400000;
	localparam longint ONE24 = 64'sd1 << 24;

	// Register settings per phase, in register index order
	localparam logic [15:0] PHASE_CFG [NUM_PHASES][8] = '{
		'{16'd2867, 16'd655, 16'd25600, 16'd20001, 16'd8192, 16'd8192, 16'd18318, 16'd4588},
		'{16'd1, 16'd1, 16'd65535, 16'd3, 16'h7FFF, 16'h8000, 16'd0, 16'd0},
		'{16'd65535, 16'd65535, 16'd1, 16'd65535, 16'h8000, 16'h7FFF, 16'h8000, 16'd65535},
		'{16'd409, 16'd6554, 16'd2560, 16'd500, 16'hE000, 16'd4096, 16'h7FFF, 16'd1000},
		'{16'd64, 16'd655, 16'd25600, 16'd3000, 16'd100, 16'hFF9C, 16'hB872, 16'd0},
		'{16'd4096, 16'd1000, 16'd700, 16'd32768, 16'd1, 16'd2, 16'd3, 16'd20000}
	};
	localparam int PHASE_IDLE [NUM_PHASES] = '{12, 12, 55, 55, 0, 0};

	typedef struct packed {
		logic               act;
		logic [14:0]        idx;
		logic signed [15:0] e1;
		logic signed [15:0] e2;
		logic signed [15:0] eg;
		logic signed [10:0] ox;
		logic signed [10:0] oy;
	} command_t;

	typedef struct packed {
		logic signed [15:0] p1x;
		logic signed [15:0] p1y;
		logic signed [15:0] p2x;
		logic signed [15:0] p2y;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic               off;
	} field_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               action = 1'b0;
	logic [14:0]        entry_index = '0;
	logic signed [15:0] entry_phi1 = '0;
	logic signed [15:0] entry_phi2 = '0;
	logic signed [15:0] entry_gauge = '0;
	logic signed [10:0] offset_x = '0;
	logic signed [10:0] offset_y = '0;
	logic               cfg_write = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               done;
	logic signed [15:0] phi1_x, phi1_y, phi2_x, phi2_y, gauge_x, gauge_y;
	logic               off_table;

	radial_profile_vortex_field_top uut (.*);

	always #5 clk = ~clk;

	// Testbench copy of registers and profile store
	logic [15:0]        reg_val [8];
	logic signed [15:0] prof_phi1 [DEF_TABLE_DEPTH];
	logic signed [15:0] prof_phi2 [DEF_TABLE_DEPTH];
	logic signed [15:0] prof_gauge [DEF_TABLE_DEPTH];
	bit                 staged [DEF_TABLE_DEPTH];

	command_t pending_cmds [$];
	field_t   expected_fields [$];
	int       idle_pct = 12;
	int       errors = 0;
	int       cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_shift(longint v, int n);
		return (v + (64'sd1 << (n - 1))) >>> n;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint a, q;
		a = num < 0 ? -num : num;
		q = (a + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// Work out the geometry of a point: position, distance, table slot
	function automatic void locate(input logic signed [10:0] ox, oy,
			output longint x, y, s24, d, p, s, output bit core, off);
		longint u, n;
		x = longint'(ox) * longint'(reg_val[REG_GRID_STEP]);
		y = longint'(oy) * longint'(reg_val[REG_GRID_STEP]);
		s24 = x * x + y * y;
		d = longint'(int_sqrt(longint'(s24) << 8));
		core = (d == 0) || (d < longint'(reg_val[REG_CORE_CUTOFF]));
		u = d * longint'(reg_val[REG_TAB_INV]);
		p = (u + (64'sd1 << 23)) >>> 24;
		s = u - (p <<< 24);
		n = reg_val[REG_TAB_ENTRIES] < DEF_TABLE_DEPTH ?
			longint'(reg_val[REG_TAB_ENTRIES]) : DEF_TABLE_DEPTH;
		off = (p + 1 >= n);
	endfunction

	function automatic longint blend(int which, longint p, longint s);
		longint f [3];
		longint acc, wm, w0, wp;
		int k;
		for (k = 0; k < 3; k++) begin
			int i;
			i = (p == 0) ? k : int'(p) - 1 + k;
			if (k == 2 && p == 0)
				i = 1;
			f[k] = which == 0 ? prof_phi1[i] : which == 1 ? prof_phi2[i] : prof_gauge[i];
		end
		if (p == 0) begin
			acc = (ONE24 - s) * f[0] + s * f[1];
		end else begin
			wm = round_shift(s * (s - ONE24), 25);
			w0 = ONE24 - round_shift(s * s, 24);
			wp = round_shift(s * (s + ONE24), 25);
			acc = wm * f[0] + w0 * f[1] + wp * f[2];
		end
		return round_shift(acc, 24);
	endfunction

	function automatic field_t field_at(logic signed [10:0] ox, oy);
		longint x, y, s24, d, p, s, m1, m2, mg;
		bit core, off;
		field_t r;
		r = '0;
		locate(ox, oy, x, y, s24, d, p, s, core, off);
		if (core)
			return r;
		if (off) begin
			m1 = longint'($signed(reg_val[REG_FAR_PHI1]));
			m2 = longint'($signed(reg_val[REG_FAR_PHI2]));
			mg = longint'($signed(reg_val[REG_FAR_GAUGE]));
		end else begin
			m1 = blend(0, p, s);
			m2 = blend(1, p, s);
			mg = blend(2, p, s);
		end
		r.p1x = clip16(round_div(m1 * x * 16, d));
		r.p1y = clip16(round_div(m1 * y * 16, d));
		r.p2x = clip16(round_div(m2 * x * 16, d));
		r.p2y = clip16(round_div(m2 * y * 16, d));
		r.gx  = clip16(round_div(-mg * y * 4096, s24));
		r.gy  = clip16(round_div(mg * x * 4096, s24));
		r.off = off;
		return r;
	endfunction

	task automatic queue_load(logic [14:0] idx, logic signed [15:0] v1, v2, vg);
		command_t c;
		c = '0;
		c.act = ACT_LOAD;
		c.idx = idx;
		c.e1 = v1;
		c.e2 = v2;
		c.eg = vg;
		staged[idx] = 1'b1;
		pending_cmds.push_back(c);
	endtask

	// Queue a point, loading any table entry it reads that is still empty
	task automatic queue_point(logic signed [10:0] ox, oy);
		longint x, y, s24, d, p, s, lo;
		bit core, off;
		command_t c;
		locate(ox, oy, x, y, s24, d, p, s, core, off);
		if (!core && !off) begin
			lo = p == 0 ? 0 : p - 1;
			for (longint i = lo; i <= lo + 2 && i <= p + 1; i++)
				if (!staged[i])
					queue_load(i[14:0], 16'($urandom), 16'($urandom), 16'($urandom));
		end
		c = '0;
		c.act = ACT_POINT;
		c.ox = ox;
		c.oy = oy;
		pending_cmds.push_back(c);
	endtask

	function automatic logic signed [10:0] pick_offset();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 11'($signed($urandom_range(30)) - 15);
		if (r < 80)
			return 11'($signed($urandom_range(400)) - 200);
		return 11'($urandom);
	endfunction

	// Driver: present queued transactions, apply them to the model on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			cycles <= cycles + 1;
			if (start && !busy) begin
				if (action == ACT_LOAD) begin
					prof_phi1[entry_index] = entry_phi1;
					prof_phi2[entry_index] = entry_phi2;
					prof_gauge[entry_index] = entry_gauge;
				end else begin
					expected_fields.push_back(field_at(offset_x, offset_y));
				end
			end
			if (!start || !busy) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
					command_t c;
					c = pending_cmds.pop_front();
					start <= 1'b1;
					action <= c.act;
					entry_index <= c.idx;
					entry_phi1 <= c.e1;
					entry_phi2 <= c.e2;
					entry_gauge <= c.eg;
					offset_x <= c.ox;
					offset_y <= c.oy;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint e, longint a);
		if (e != a) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, e, a);
			errors++;
		end
	endtask

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_fields.size() == 0) begin
				$display("%0t: unexpected result, expected none got phi1_x %0d",
					$time, phi1_x);
				errors++;
			end else begin
				field_t e;
				e = expected_fields.pop_front();
				check_field("phi1_x", e.p1x, phi1_x);
				check_field("phi1_y", e.p1y, phi1_y);
				check_field("phi2_x", e.p2x, phi2_x);
				check_field("phi2_y", e.p2y, phi2_y);
				check_field("gauge_x", e.gx, gauge_x);
				check_field("gauge_y", e.gy, gauge_y);
				check_field("off_table", e.off, off_table);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Configure while idle
			for (int i = 0; i < 8; i++) begin
				@(posedge clk);
				cfg_write <= 1'b1;
				cfg_index <= 3'(i);
				cfg_data <= PHASE_CFG[ph][i];
				reg_val[i] = PHASE_CFG[ph][i];
			end
			@(posedge clk);
			cfg_write <= 1'b0;
			idle_pct = PHASE_IDLE[ph];
			if (ph == 1) begin
				// Linear slot, quadratic slot, last entry, core and offset extremes
				queue_load(15'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
				queue_load(15'd1, 16'sh8000, 16'sh7FFF, 16'sh8000);
				queue_load(15'd2, 16'sd0, 16'sd1, -16'sd1);
				queue_point(0, 0);
				queue_point(1, 0);
				queue_point(0, 1);
				queue_point(-1, -1);
				queue_point(7, 0);
				queue_point(8, 0);
				queue_point(16, 5);
				queue_point(-12, 13);
				queue_point(24, 0);
				queue_point(-1024, 1023);
				queue_point(1023, -1024);
				queue_point(-1024, -1024);
			end
			for (int k = 0; k < 120; k++) begin
				if ($urandom_range(99) < 15)
					queue_load(15'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				else
					queue_point(pick_offset(), pick_offset());
			end
			// Drain, then let trailing loads clear the pipe
			while (pending_cmds.size() > 0 || start || expected_fields.size() > 0)
				@(posedge clk);
			repeat (PIPE_LAT + 8) @(posedge clk);
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
